[src/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes, character constants and lookup functions for the
// C-subset token scanner.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int CST_LEXEME_BYTES = 8;
    localparam int CST_LINE_BITS    = 16;
    localparam int RQ_DEPTH         = 4;

    // Scanner modes
    localparam int MODE_W = 4;
    localparam logic [MODE_W-1:0] M_IDLE    = 4'd0;
    localparam logic [MODE_W-1:0] M_IDENT   = 4'd1;
    localparam logic [MODE_W-1:0] M_NUMINT  = 4'd2;
    localparam logic [MODE_W-1:0] M_NUMFRAC = 4'd3;
    localparam logic [MODE_W-1:0] M_COMMENT = 4'd4;
    localparam logic [MODE_W-1:0] M_SLASH   = 4'd5;
    localparam logic [MODE_W-1:0] M_LT      = 4'd6;
    localparam logic [MODE_W-1:0] M_GT      = 4'd7;
    localparam logic [MODE_W-1:0] M_EQ      = 4'd8;
    localparam logic [MODE_W-1:0] M_NOT     = 4'd9;
    localparam logic [MODE_W-1:0] M_OR      = 4'd10;
    localparam logic [MODE_W-1:0] M_AMP     = 4'd11;

    // Token codes
    localparam logic [5:0] TK_PLUS   = 6'd0;
    localparam logic [5:0] TK_MINUS  = 6'd1;
    localparam logic [5:0] TK_TIMES  = 6'd2;
    localparam logic [5:0] TK_SLASH  = 6'd3;
    localparam logic [5:0] TK_MOD    = 6'd4;
    localparam logic [5:0] TK_LPAREN = 6'd5;
    localparam logic [5:0] TK_RPAREN = 6'd6;
    localparam logic [5:0] TK_LBRACE = 6'd7;
    localparam logic [5:0] TK_RBRACE = 6'd8;
    localparam logic [5:0] TK_SEMI   = 6'd9;
    localparam logic [5:0] TK_COMMA  = 6'd10;
    localparam logic [5:0] TK_LSS    = 6'd11;
    localparam logic [5:0] TK_LEQ    = 6'd12;
    localparam logic [5:0] TK_GTR    = 6'd13;
    localparam logic [5:0] TK_GEQ    = 6'd14;
    localparam logic [5:0] TK_ASSIGN = 6'd15;
    localparam logic [5:0] TK_EQL    = 6'd16;
    localparam logic [5:0] TK_NOT    = 6'd17;
    localparam logic [5:0] TK_NEQ    = 6'd18;
    localparam logic [5:0] TK_OR     = 6'd19;
    localparam logic [5:0] TK_AND    = 6'd20;
    localparam logic [5:0] TK_NAL    = 6'd21;
    localparam logic [5:0] TK_EOI    = 6'd22;
    localparam logic [5:0] TK_KW0    = 6'd23;
    localparam logic [5:0] TK_IDENT  = 6'd36;
    localparam logic [5:0] TK_NUMBER = 6'd37;

    // Characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keywords, packed first character in the low byte
    localparam int KW_COUNT = 13;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0074_6e69,  // int
        64'h0000_0074_616f_6c66,  // float
        64'h0000_0000_6c6f_6f62,  // bool
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_6573_6c65,  // else
        64'h0000_0000_0072_6f66,  // for
        64'h0000_0065_6c69_6877,  // while
        64'h0000_0000_6575_7274,  // true
        64'h0000_0065_736c_6166,  // false
        64'h0000_6e72_7574_6572,  // return
        64'h0000_0066_6e61_6373,  // scanf
        64'h0000_6674_6e69_7270,  // printf
        64'h0000_0000_6469_6f76   // void
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd5, 8'd4, 8'd2, 8'd4, 8'd3, 8'd5, 8'd4, 8'd5, 8'd6, 8'd5, 8'd6, 8'd4
    };

    typedef struct packed {
        logic [5:0]  code;
        logic [63:0] bytes;
        logic [7:0]  len;
        logic        ovf;
        logic [15:0] line;
        logic        last;
    } t_result;

    // Results produced by one accepted word, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [5:0] keyword_code(input logic [63:0] text,
                                                input logic [7:0] len,
                                                input int lex_bytes);
        logic [5:0] code;
        code = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (len == KW_LEN[k] && int'(KW_LEN[k]) <= lex_bytes && text == KW_TEXT[k]) begin
                code = 6'(int'(TK_KW0) + k);
            end
        end
        return code;
    endfunction

    // Mode entered by an operator that may pair with a second character.
    function automatic logic [MODE_W-1:0] lead_mode(input logic [7:0] c);
        logic [MODE_W-1:0] m;
        case (c)
            CH_SLASH: m = M_SLASH;
            CH_LT:    m = M_LT;
            CH_GT:    m = M_GT;
            CH_EQ:    m = M_EQ;
            CH_BANG:  m = M_NOT;
            CH_BAR:   m = M_OR;
            CH_AMP:   m = M_AMP;
            default:  m = M_IDLE;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] code;
        case (c)
            CH_PLUS:   code = TK_PLUS;
            CH_MINUS:  code = TK_MINUS;
            CH_STAR:   code = TK_TIMES;
            CH_PCT:    code = TK_MOD;
            CH_LPAREN: code = TK_LPAREN;
            CH_RPAREN: code = TK_RPAREN;
            CH_LBRACE: code = TK_LBRACE;
            CH_RBRACE: code = TK_RBRACE;
            CH_SEMI:   code = TK_SEMI;
            CH_COMMA:  code = TK_COMMA;
            default:   code = TK_NAL;
        endcase
        return code;
    endfunction

    // Token for an operator character that found no partner.
    function automatic logic [5:0] op_single(input logic [MODE_W-1:0] m);
        logic [5:0] code;
        case (m)
            M_SLASH: code = TK_SLASH;
            M_LT:    code = TK_LSS;
            M_GT:    code = TK_GTR;
            M_EQ:    code = TK_ASSIGN;
            M_NOT:   code = TK_NOT;
            default: code = TK_NAL;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] op_second(input logic [MODE_W-1:0] m);
        logic [7:0] c;
        case (m)
            M_SLASH: c = CH_SLASH;
            M_OR:    c = CH_BAR;
            M_AMP:   c = CH_AMP;
            default: c = CH_EQ;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] op_pair(input logic [MODE_W-1:0] m);
        logic [5:0] code;
        case (m)
            M_LT:    code = TK_LEQ;
            M_GT:    code = TK_GEQ;
            M_EQ:    code = TK_EQL;
            M_NOT:   code = TK_NEQ;
            M_OR:    code = TK_OR;
            M_AMP:   code = TK_AND;
            default: code = TK_NAL;
        endcase
        return code;
    endfunction

endpackage

[src/c_subset_token_scanner.sv]
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Lexer for a small C subset: one source byte in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one source byte per word in s_axis_tdata; a word
//   with s_axis_tlast high marks end of input, flushes any pending token and
//   produces an EOI token (its data byte is ignored). The master channel
//   gives one token per word; m_axis_tlast marks the last token caused by
//   one input word.
//   A token enters the result queue in the cycle after the word that causes
//   it is taken. The block takes one byte per cycle while s_axis_tready is
//   high; a byte that ends one token and is itself a token gives two tokens,
//   which leave one after the other through the four-entry result queue. A
//   run of such bytes is held back by the queue even when the master side
//   never stalls, as it takes the tokens one at a time. s_axis_tready is high
//   while that queue holds at most two tokens, so a stalled receiver keeps
//   the tokens in the queue and input stops once three or more tokens wait;
//   bytes that give no token keep passing until then.
//   Reset (synchronous, active low) empties the queue, returns the scanner
//   to idle and sets the line count to one.
// ----------------------------------------------------------------------------
module c_subset_token_scanner #(
    parameter int LEXEME_BYTES = cst_pkg::CST_LEXEME_BYTES,
    parameter int LINE_BITS    = cst_pkg::CST_LINE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [5:0] token_code, [69:6] lexeme_bytes,
                                        // [77:70] lexeme_length, [78] lexeme_overflow,
                                        // [94:79] line_number, [95] zero
    output logic        m_axis_tlast    // last_result
);
    import cst_pkg::*;

    logic    accept, space;
    t_push   push;
    t_result res;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    cst_scan_core #(
        .LEXEME_BYTES (LEXEME_BYTES),
        .LINE_BITS    (LINE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (s_axis_tdata),
        .i_eoi    (s_axis_tlast),
        .o_push   (push)
    );

    cst_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    assign m_axis_tdata = {1'b0, res.line, res.ovf, res.len, res.bytes, res.code};
    assign m_axis_tlast = res.last;

endmodule

[src/cst_scan_core.sv]
// ----------------------------------------------------------------------------
// cst_scan_core
// Scanner state registers and the single-pass next-state and token logic.
// Each accepted word yields zero, one or two tokens.
// ----------------------------------------------------------------------------
module cst_scan_core #(
    parameter int LEXEME_BYTES = cst_pkg::CST_LEXEME_BYTES,
    parameter int LINE_BITS    = cst_pkg::CST_LINE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char,
    input  logic           i_eoi,
    output cst_pkg::t_push o_push
);
    import cst_pkg::*;

    localparam int BUF_W = LEXEME_BYTES * 8;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [BUF_W-1:0]     r_buf, n_buf;
    logic [7:0]           r_cnt, n_cnt;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [LINE_BITS-1:0] r_start, n_start;

    logic [MODE_W-1:0]    idle_mode;
    logic [BUF_W-1:0]     idle_buf, add_buf;
    logic [7:0]           idle_cnt, add_cnt;
    logic [LINE_BITS-1:0] idle_line, idle_start, line_inc;
    logic                 idle_v, f_v, a_v, b_v, brk;
    t_result              idle_res, f_res, a_res, b_res;

    function automatic t_result mk(input logic [5:0] code, input logic [63:0] bytes,
                                   input logic [7:0] len, input logic [LINE_BITS-1:0] line);
        t_result r;
        r.code  = code;
        r.bytes = bytes;
        r.len   = len;
        r.ovf   = len > 8'(LEXEME_BYTES);
        r.line  = 16'(line);
        r.last  = 1'b0;
        return r;
    endfunction

    assign line_inc = (r_line != LINE_MAX) ? r_line + LINE_ONE : r_line;

    // Append the character to the current lexeme.
    always_comb begin
        add_buf = r_buf;
        for (int b = 0; b < LEXEME_BYTES; b++) begin
            if (r_cnt == 8'(b)) begin
                add_buf[b*8 +: 8] = i_char;
            end
        end
        add_cnt = (r_cnt != 8'd255) ? r_cnt + 8'd1 : r_cnt;
    end

    // Pending token flushed when a lexeme ends.
    always_comb begin
        f_v   = 1'b0;
        f_res = mk(TK_IDENT, 64'(r_buf), r_cnt, r_start);
        case (r_mode)
            M_IDENT: begin
                f_v   = 1'b1;
                f_res = mk(keyword_code(64'(r_buf), r_cnt, LEXEME_BYTES),
                           64'(r_buf), r_cnt, r_start);
            end
            M_NUMINT, M_NUMFRAC: begin
                f_v   = 1'b1;
                f_res = mk(TK_NUMBER, 64'(r_buf), r_cnt, r_start);
            end
            M_SLASH, M_LT, M_GT, M_EQ, M_NOT, M_OR, M_AMP: begin
                f_v   = 1'b1;
                f_res = mk(op_single(r_mode), 64'(r_buf), 8'd1, r_start);
            end
            default: begin
                f_v = 1'b0;
            end
        endcase
    end

    // Handling of the character as if the scanner were idle.
    always_comb begin
        idle_mode  = M_IDLE;
        idle_buf   = r_buf;
        idle_cnt   = r_cnt;
        idle_line  = r_line;
        idle_start = r_start;
        idle_v     = 1'b0;
        idle_res   = mk(single_code(i_char), 64'(i_char), 8'd1, r_line);
        if (i_char == CH_NL) begin
            idle_line = line_inc;
        end else if (is_space(i_char)) begin
            idle_mode = M_IDLE;
        end else if (is_letter(i_char) || is_digit(i_char) || lead_mode(i_char) != M_IDLE) begin
            if (is_letter(i_char)) begin
                idle_mode = M_IDENT;
            end else if (is_digit(i_char)) begin
                idle_mode = M_NUMINT;
            end else begin
                idle_mode = lead_mode(i_char);
            end
            idle_buf   = BUF_W'(i_char);
            idle_cnt   = 8'd1;
            idle_start = r_line;
        end else begin
            idle_v = 1'b1;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_line  = r_line;
        n_start = r_start;
        brk     = 1'b0;
        a_v     = 1'b0;
        a_res   = f_res;
        b_v     = 1'b0;
        b_res   = idle_res;
        if (i_eoi) begin
            a_v    = f_v;
            b_v    = 1'b1;
            b_res  = mk(TK_EOI, 64'd0, 8'd0, r_line);
            n_mode = M_IDLE;
            n_buf  = '0;
            n_cnt  = 8'd0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (is_letter(i_char) || is_digit(i_char)) begin
                        n_buf = add_buf;
                        n_cnt = add_cnt;
                    end else begin
                        brk = 1'b1;
                    end
                end
                M_NUMINT: begin
                    if (is_digit(i_char) || i_char == CH_DOT) begin
                        n_buf = add_buf;
                        n_cnt = add_cnt;
                        if (i_char == CH_DOT) begin
                            n_mode = M_NUMFRAC;
                        end
                    end else begin
                        brk = 1'b1;
                    end
                end
                M_NUMFRAC: begin
                    if (is_digit(i_char)) begin
                        n_buf = add_buf;
                        n_cnt = add_cnt;
                    end else begin
                        brk = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_char == CH_NL) begin
                        n_line = line_inc;
                        n_mode = M_IDLE;
                    end
                end
                M_SLASH: begin
                    if (i_char == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        brk = 1'b1;
                    end
                end
                M_LT, M_GT, M_EQ, M_NOT, M_OR, M_AMP: begin
                    if (i_char == op_second(r_mode)) begin
                        a_v    = 1'b1;
                        a_res  = mk(op_pair(r_mode), {48'd0, i_char, r_buf[7:0]},
                                    8'd2, r_start);
                        n_mode = M_IDLE;
                    end else begin
                        brk = 1'b1;
                    end
                end
                default: begin
                    brk = 1'b1;
                end
            endcase
            if (brk) begin
                // A flushed token comes ahead of anything this character starts.
                a_v     = f_v;
                b_v     = idle_v;
                n_mode  = idle_mode;
                n_buf   = idle_buf;
                n_cnt   = idle_cnt;
                n_line  = idle_line;
                n_start = idle_start;
            end
        end
    end

    always_comb begin
        o_push.count   = {1'b0, a_v} + {1'b0, b_v};
        o_push.r0      = a_v ? a_res : b_res;
        o_push.r0.last = !(a_v && b_v);
        o_push.r1      = b_res;
        o_push.r1.last = 1'b1;
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_buf   <= '0;
            r_cnt   <= 8'd0;
            r_line  <= LINE_ONE;
            r_start <= LINE_ONE;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
            r_line  <= n_line;
            r_start <= n_start;
        end
    end

endmodule

[src/cst_result_queue.sv]
// ----------------------------------------------------------------------------
// cst_result_queue
// Small register queue that takes up to two tokens per cycle and hands one
// token per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module cst_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cst_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output cst_pkg::t_result o_result
);
    import cst_pkg::*;

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    t_result          r_mem [RQ_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_valid  = r_count != '0;
    assign pop      = o_valid && i_ready;
    // Room for the largest burst one word can cause.
    assign o_space  = r_count <= CNT_W'(RQ_DEPTH - 2);
    assign o_result = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(i_push.count);
            r_rp    <= r_rp + PTR_W'(pop);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RQ_DEPTH))
        else $error("result queue count out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_space)
        else $error("tokens pushed without room in the result queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + CNT_W'($past(i_push.count))
                                      - CNT_W'($past(pop)))
        else $error("result queue count does not follow pushes and pops");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the C-subset token scanner. Source bytes go in on
// the input stream and a bit-accurate scanner model running alongside
// predicts the token stream. Every token word on the output stream is
// compared field by field with the oldest prediction. Both sides idle at
// random outside one stretch of the random test.
// ----------------------------------------------------------------------------
module testbench;
    import cst_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          RANDOM_WORDS   = 650;
    localparam logic [15:0] LINE_TOP       = 16'hFFFF;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // [5:0] token_code, [69:6] lexeme_bytes,
                                         // [77:70] lexeme_length, [78] lexeme_overflow,
                                         // [94:79] line_number, [95] zero
    logic        m_axis_tlast;           // last_result

    c_subset_token_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Scanner model state.
    logic [MODE_W-1:0] scan_state = M_IDLE;
    logic [63:0]       lex_text   = 64'd0;
    logic [7:0]        lex_len    = 8'd0;
    logic [15:0]       cur_line   = 16'd1;
    logic [15:0]       tok_line   = 16'd1;
    t_result           tokens_due[$];

    int errors       = 0;
    int words_sent   = 0;
    int quiet_cycles = 0;
    bit src_pauses   = 1'b1;
    bit sink_pauses  = 1'b1;

    string keywords[13] = '{"int", "float", "bool", "if", "else", "for", "while",
                            "true", "false", "return", "scanf", "printf", "void"};
    string operators[23] = '{"+", "-", "*", "/", "%", "(", ")", "{", "}", ";", ",",
                             "<", "<=", ">", ">=", "=", "==", "!", "!=", "||", "&&",
                             "|", "&"};

    function automatic bit letter_ch(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit blank_ch(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [5:0] punct_token(input logic [7:0] c);
        logic [5:0] code;
        case (c)
            CH_PLUS:   code = TK_PLUS;
            CH_MINUS:  code = TK_MINUS;
            CH_STAR:   code = TK_TIMES;
            CH_PCT:    code = TK_MOD;
            CH_LPAREN: code = TK_LPAREN;
            CH_RPAREN: code = TK_RPAREN;
            CH_LBRACE: code = TK_LBRACE;
            CH_RBRACE: code = TK_RBRACE;
            CH_SEMI:   code = TK_SEMI;
            CH_COMMA:  code = TK_COMMA;
            default:   code = TK_NAL;
        endcase
        return code;
    endfunction

    function automatic logic [MODE_W-1:0] lead_state(input logic [7:0] c);
        logic [MODE_W-1:0] m;
        case (c)
            CH_SLASH: m = M_SLASH;
            CH_LT:    m = M_LT;
            CH_GT:    m = M_GT;
            CH_EQ:    m = M_EQ;
            CH_BANG:  m = M_NOT;
            CH_BAR:   m = M_OR;
            CH_AMP:   m = M_AMP;
            default:  m = M_IDLE;
        endcase
        return m;
    endfunction

    // For a state holding an operator character: the character that completes
    // a pair, the token of that pair, and the token when it stays alone.
    function automatic void op_info(input logic [MODE_W-1:0] m, output logic [7:0] partner,
                                    output logic [5:0] pair_tk, output logic [5:0] lone_tk);
        partner = CH_EQ;
        pair_tk = TK_NAL;
        lone_tk = TK_NAL;
        case (m)
            M_SLASH: begin
                partner = CH_SLASH;
                lone_tk = TK_SLASH;
            end
            M_LT: begin
                pair_tk = TK_LEQ;
                lone_tk = TK_LSS;
            end
            M_GT: begin
                pair_tk = TK_GEQ;
                lone_tk = TK_GTR;
            end
            M_EQ: begin
                pair_tk = TK_EQL;
                lone_tk = TK_ASSIGN;
            end
            M_NOT: begin
                pair_tk = TK_NEQ;
                lone_tk = TK_NOT;
            end
            M_OR: begin
                partner = CH_BAR;
                pair_tk = TK_OR;
            end
            M_AMP: begin
                partner = CH_AMP;
                pair_tk = TK_AND;
            end
            default: begin
            end
        endcase
    endfunction

    // Keywords match only on exact length and exact bytes.
    function automatic logic [5:0] word_token();
        logic [63:0] kw_bits;
        logic [5:0]  code;
        code = TK_IDENT;
        for (int k = 0; k < 13; k++) begin
            if (keywords[k].len() == int'(lex_len)) begin
                kw_bits = 64'd0;
                for (int i = 0; i < keywords[k].len(); i++)
                    kw_bits[8*i +: 8] = keywords[k][i];
                if (kw_bits == lex_text) code = TK_KW0 + 6'(k);
            end
        end
        return code;
    endfunction

    task automatic push_token(input logic [5:0] code, input logic [63:0] text,
                              input logic [7:0] len, input logic [15:0] at_line);
        t_result r;
        r.code  = code;
        r.bytes = text;
        r.len   = len;
        r.ovf   = (len > 8'd8);
        r.line  = at_line;
        r.last  = 1'b0;
        tokens_due.push_back(r);
    endtask

    task automatic bump_line();
        if (cur_line != LINE_TOP) cur_line++;
    endtask

    task automatic take_char(input logic [7:0] c);
        if (lex_len < 8'd8) lex_text[8*lex_len +: 8] = c;
        if (lex_len != 8'hFF) lex_len++;
    endtask

    task automatic open_lexeme(input logic [7:0] c, input logic [MODE_W-1:0] m);
        lex_text = 64'd0;
        lex_len  = 8'd0;
        tok_line = cur_line;
        take_char(c);
        scan_state = m;
    endtask

    task automatic flush_token();
        logic [7:0] partner;
        logic [5:0] pair_tk;
        logic [5:0] lone_tk;
        if (scan_state == M_IDENT) begin
            push_token(word_token(), lex_text, lex_len, tok_line);
        end else if (scan_state == M_NUMINT || scan_state == M_NUMFRAC) begin
            push_token(TK_NUMBER, lex_text, lex_len, tok_line);
        end else if (scan_state >= M_SLASH && scan_state <= M_AMP) begin
            op_info(scan_state, partner, pair_tk, lone_tk);
            push_token(lone_tk, lex_text, 8'd1, tok_line);
        end
        scan_state = M_IDLE;
    endtask

    task automatic begin_char(input logic [7:0] c);
        scan_state = M_IDLE;
        if (c == CH_NL) begin
            bump_line();
        end else if (!blank_ch(c)) begin
            if (letter_ch(c)) open_lexeme(c, M_IDENT);
            else if (digit_ch(c)) open_lexeme(c, M_NUMINT);
            else if (lead_state(c) != M_IDLE) open_lexeme(c, lead_state(c));
            else push_token(punct_token(c), {56'd0, c}, 8'd1, cur_line);
        end
    endtask

    // Advances the model by one accepted word and queues the tokens it causes.
    task automatic scan_word(input logic [7:0] c, input logic eoi);
        int         due_count;
        t_result    tail;
        logic [7:0] partner;
        logic [5:0] pair_tk;
        logic [5:0] lone_tk;
        due_count = tokens_due.size();
        if (eoi) begin
            flush_token();
            push_token(TK_EOI, 64'd0, 8'd0, cur_line);
            lex_text = 64'd0;
            lex_len  = 8'd0;
        end else begin
            case (scan_state)
                M_IDLE: begin_char(c);
                M_IDENT: begin
                    if (letter_ch(c) || digit_ch(c)) begin
                        take_char(c);
                    end else begin
                        flush_token();
                        begin_char(c);
                    end
                end
                M_NUMINT: begin
                    if (digit_ch(c)) begin
                        take_char(c);
                    end else if (c == CH_DOT) begin
                        take_char(c);
                        scan_state = M_NUMFRAC;
                    end else begin
                        flush_token();
                        begin_char(c);
                    end
                end
                M_NUMFRAC: begin
                    if (digit_ch(c)) begin
                        take_char(c);
                    end else begin
                        flush_token();
                        begin_char(c);
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        bump_line();
                        scan_state = M_IDLE;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan_state = M_COMMENT;
                    end else begin
                        flush_token();
                        begin_char(c);
                    end
                end
                default: begin
                    op_info(scan_state, partner, pair_tk, lone_tk);
                    if (c == partner) begin
                        push_token(pair_tk, {48'd0, c, lex_text[7:0]}, 8'd2, tok_line);
                        scan_state = M_IDLE;
                    end else begin
                        flush_token();
                        begin_char(c);
                    end
                end
            endcase
        end
        if (tokens_due.size() > due_count) begin
            tail = tokens_due.pop_back();
            tail.last = 1'b1;
            tokens_due.push_back(tail);
        end
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            errors++;
        end
    endtask

    task automatic check_token();
        t_result want;
        if (tokens_due.size() == 0) begin
            $display("%0t: token word %h with none expected", $time, m_axis_tdata);
            errors++;
        end else begin
            want = tokens_due.pop_front();
            compare_field("token_code", 64'(want.code), 64'(m_axis_tdata[5:0]));
            compare_field("lexeme_bytes", want.bytes, m_axis_tdata[69:6]);
            compare_field("lexeme_length", 64'(want.len), 64'(m_axis_tdata[77:70]));
            compare_field("lexeme_overflow", 64'(want.ovf), 64'(m_axis_tdata[78]));
            compare_field("line_number", 64'(want.line), 64'(m_axis_tdata[94:79]));
            compare_field("last_result", 64'(want.last), 64'(m_axis_tlast));
        end
    endtask

    // Valid is only lowered inside the gap loop, so it never drops and rises
    // again in one time step between back-to-back words.
    task automatic send_word(input logic [7:0] c, input logic eoi);
        while (src_pauses && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        scan_word(c, eoi);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1)) return 8'(CH_LA + $urandom_range(25));
        return 8'(CH_UA + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_alnum();
        if ($urandom_range(5) == 0) return 8'(CH_0 + $urandom_range(9));
        return random_letter();
    endfunction

    function automatic logic [7:0] random_blank();
        int r;
        r = $urandom_range(5);
        if (r == 5) return CH_SPACE;
        return 8'(CH_TAB + r);
    endfunction

    // One well-formed piece of source with random content.
    task automatic send_lexeme();
        int pick;
        int n;
        int k;
        pick = $urandom_range(99);
        if (pick < 20) begin
            send_text(keywords[$urandom_range(12)]);
        end else if (pick < 45) begin
            send_text(operators[$urandom_range(22)]);
        end else if (pick < 65) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 9);
            send_word(random_letter(), 1'b0);
            for (int i = 1; i < n; i++) send_word(random_alnum(), 1'b0);
        end else if (pick < 73) begin
            // Near misses of a keyword: one character short or one too long.
            k = $urandom_range(12);
            if ($urandom_range(1)) begin
                send_text(keywords[k].substr(0, keywords[k].len() - 2));
            end else begin
                send_text(keywords[k]);
                send_word(random_alnum(), 1'b0);
            end
        end else if (pick < 88) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_word(8'(CH_0 + $urandom_range(9)), 1'b0);
            if ($urandom_range(1)) begin
                send_word(CH_DOT, 1'b0);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) send_word(8'(CH_0 + $urandom_range(9)), 1'b0);
            end
        end else if (pick < 95) begin
            send_text("//");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) send_word(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(4) != 0) send_word(CH_NL, 1'b0);
        end else begin
            send_word(random_blank(), 1'b0);
        end
    endtask

    task automatic test_specials();
        send_text("a+");               // one word ends a token and is a token itself
        send_word(8'hFF, 1'b0);        // unknown bytes
        send_word(8'h00, 1'b0);
        send_text("| &");              // lone bar, then a lone ampersand flushed by end
        send_word(8'h00, 1'b1);
        send_text("//x");              // open comment at end of input gives only EOI
        send_word(8'hFF, 1'b1);
        send_text("iff in 3.5;");      // near keywords and a fraction
    endtask

    task automatic test_lexeme_length();
        send_text("abcdefgh abcdefghi ");
        for (int i = 0; i < 300; i++) send_word(CH_LA, 1'b0);
        send_word(CH_SEMI, 1'b0);
        send_word(8'h55, 1'b1);
    endtask

    task automatic test_random();
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            // A stretch in the middle runs without any idling.
            src_pauses  = !(words_sent - start >= 300 && words_sent - start < 500);
            sink_pauses = src_pauses;
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_word(8'($urandom_range(255)), 1'b0);
            end else if (pick < 11) begin
                send_word(8'($urandom_range(255)), 1'b1);
            end else begin
                send_lexeme();
                if ($urandom_range(1)) send_word(random_blank(), 1'b0);
            end
        end
        src_pauses  = 1'b1;
        sink_pauses = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_token();
            m_axis_tready <= !(sink_pauses && $urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_specials();
        test_lexeme_length();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
